>>> hdl/opcd_pkg.sv
// Shared widths, register indexes and fixed-point constants for the ordered probit category draw.
package opcd_pkg;

    localparam int XB_W        = 24;
    localparam int U_W         = 16;
    localparam int PROB_W      = 17;
    localparam int CAT_W       = 3;
    localparam int NCUT_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int FRAC_W      = 19;

    typedef logic [PROB_W-1:0] prob_t;

    localparam prob_t PROB_ONE  = 17'h10000;
    localparam prob_t PROB_HALF = 17'h08000;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CUTS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUT_POINT_0 = 3'd1;

    localparam logic [63:0] ONE_Q32          = 64'h0000_0001_0000_0000;
    localparam logic [63:0] LN2_Q32          = 64'd2977044472;
    localparam logic [63:0] INV_SQRT_2PI_Q32 = 64'd1713444002;

endpackage

>>> hdl/ordered_probit_category_draw_top.sv
// Ordered probit category draw: cut point registers, cumulative probability pipeline and result sequencer.
//
// Each accepted item (linear predictor xb, uniform draw u) yields n + 1 result items, n being
// num_cuts clamped to 1..MAX_CUTS, one per category in ascending order, each carrying that
// category's probability, the drawn ordinal and a last flag on the final one. The cumulative
// probabilities Phi(cut_i - xb) are formed for all cut points in parallel lanes over three
// pipeline stages (difference and scaling, normal CDF table read, interpolation), after which
// the results are sent one per cycle, while the output is not stalled, from a sequencer into
// an output register. The single result port limits the sustained rate; while the sequencer is
// busy, up to four further items are taken into the pipeline. The CDF table is a constant built
// during elaboration, so no initialization time is needed.
module ordered_probit_category_draw_top #(
    parameter int MAX_CUTS          = 6,
    parameter int CDF_TABLE_ENTRIES = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_wr_en,
    input  logic [opcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [opcd_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [opcd_pkg::XB_W-1:0]         linear_predictor,
    input  logic [opcd_pkg::U_W-1:0]          uniform_draw,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [opcd_pkg::CAT_W-1:0]        category,
    output logic [opcd_pkg::PROB_W-1:0]       category_prob,
    output logic                              is_chosen,
    output logic [opcd_pkg::CAT_W-1:0]        ordinal,
    output logic                              last
);
    import opcd_pkg::*;

    localparam int IDX_W = $clog2(CDF_TABLE_ENTRIES + 1);
    localparam int P_W   = FRAC_W + IDX_W;
    localparam int MUL_W = PROB_W + FRAC_W;

    localparam logic [63:0] E_SQ         = 64'(CDF_TABLE_ENTRIES * CDF_TABLE_ENTRIES);
    localparam logic [63:0] SIMPSON_DIV  = 64'(3 * CDF_TABLE_ENTRIES);
    localparam logic [63:0] SIMPSON_BIAS = 64'((3 * CDF_TABLE_ENTRIES) / 2);

    typedef logic [CDF_TABLE_ENTRIES:0][PROB_W-1:0] phi_rom_t;

    function automatic logic [63:0] div_by_term(input logic [63:0] x, input int k);
        case (k)
            1:       return x / 1;
            2:       return x / 2;
            3:       return x / 3;
            4:       return x / 4;
            5:       return x / 5;
            6:       return x / 6;
            7:       return x / 7;
            8:       return x / 8;
            9:       return x / 9;
            10:      return x / 10;
            11:      return x / 11;
            12:      return x / 12;
            13:      return x / 13;
            14:      return x / 14;
            default: return x;
        endcase
    endfunction

    // exp(-y) in Q32 as a power of two times a Taylor series of the remainder.
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] y);
        logic [63:0]  q;
        logic [63:0]  r;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] prod;
        q    = y / LN2_Q32;
        r    = y - q * LN2_Q32;
        term = ONE_Q32;
        sum  = ONE_Q32;
        for (int k = 1; k <= 14; k++)
        begin
            prod = {64'd0, term} * {64'd0, r};
            term = div_by_term(prod[95:32], k);
            if (k[0])
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        if (q >= 64)
        begin
            return 64'd0;
        end
        return sum >> q;
    endfunction

    // Normal density at half table steps, Q32.
    function automatic logic [63:0] density_at_half_step(input logic [63:0] j);
        logic [63:0]  y;
        logic [127:0] prod;
        y    = ((j * j) << 35) / E_SQ;
        prod = {64'd0, exp_neg_q32(y)} * {64'd0, INV_SQRT_2PI_Q32};
        return prod[95:32];
    endfunction

    // Simpson integration of the density, one panel per table step.
    function automatic phi_rom_t build_phi();
        phi_rom_t    t;
        logic [63:0] acc;
        logic [63:0] f0;
        logic [63:0] fm;
        logic [63:0] f1;
        logic [63:0] s;
        logic [63:0] v;
        t    = '0;
        acc  = 64'd0;
        f0   = density_at_half_step(64'd0);
        t[0] = PROB_HALF;
        for (int k = 0; k < CDF_TABLE_ENTRIES; k++)
        begin
            fm  = density_at_half_step(64'(2 * k + 1));
            f1  = density_at_half_step(64'(2 * k + 2));
            s   = f0 + 64'd4 * fm + f1;
            acc = acc + (s * 64'd4 + SIMPSON_BIAS) / SIMPSON_DIV;
            v   = (64'h8000_0000 + acc + 64'h8000) >> 16;
            if (v > 64'(PROB_ONE))
            begin
                v = 64'(PROB_ONE);
            end
            t[k + 1] = v[PROB_W-1:0];
            f0       = f1;
        end
        return t;
    endfunction

    localparam phi_rom_t PHI_ROM = build_phi();

    // Configuration registers.
    logic [NCUT_W-1:0] num_cuts_reg;
    logic [XB_W-1:0]   cut_reg [MAX_CUTS];
    logic [NCUT_W-1:0] n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cuts_reg <= NCUT_W'(1);
            for (int i = 0; i < MAX_CUTS; i++)
            begin
                cut_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_NUM_CUTS)
            begin
                num_cuts_reg <= cfg_wr_data[NCUT_W-1:0];
            end
            for (int i = 0; i < MAX_CUTS; i++)
            begin
                if (cfg_index == CFG_CUT_POINT_0 + CFG_INDEX_W'(i))
                begin
                    cut_reg[i] <= cfg_wr_data[XB_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (num_cuts_reg == '0)
        begin
            n_eff = NCUT_W'(1);
        end
        else if (num_cuts_reg > NCUT_W'(MAX_CUTS))
        begin
            n_eff = NCUT_W'(MAX_CUTS);
        end
        else
        begin
            n_eff = num_cuts_reg;
        end
    end

    // Pipeline control.
    logic pipe_en;
    logic load;
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;

    assign pipe_en  = !s3_valid_reg || load;
    assign in_ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    logic [XB_W-1:0] s0_xb_reg;
    logic [U_W-1:0]  s0_u_reg;
    logic [U_W-1:0]  s1_u_reg;
    logic [U_W-1:0]  s2_u_reg;
    logic [U_W-1:0]  s3_u_reg;
    prob_t           s3_cum_reg [MAX_CUTS];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_xb_reg <= linear_predictor;
            s0_u_reg  <= uniform_draw;
            s1_u_reg  <= s0_u_reg;
            s2_u_reg  <= s1_u_reg;
            s3_u_reg  <= s2_u_reg;
        end
    end

    // One lane per cut point computes Phi(cut - xb).
    for (genvar g = 0; g < MAX_CUTS; g++)
    begin : g_lane
        logic [XB_W:0]      d;
        logic [XB_W:0]      a;
        logic               neg_next;
        logic               sat_next;
        logic [P_W-1:0]     p;
        prob_t              lo_next;
        prob_t              hi_next;
        logic [MUL_W-1:0]   prod;
        logic [MUL_W:0]     rnd;
        logic [PROB_W:0]    sum;
        prob_t              v;
        prob_t              cum_next;

        logic               s1_neg_reg;
        logic               s1_sat_reg;
        logic [IDX_W-1:0]   s1_idx_reg;
        logic [FRAC_W-1:0]  s1_frac_reg;
        logic               s2_neg_reg;
        logic               s2_sat_reg;
        prob_t              s2_lo_reg;
        prob_t              s2_diff_reg;
        logic [FRAC_W-1:0]  s2_frac_reg;

        assign d        = {cut_reg[g][XB_W-1], cut_reg[g]} - {s0_xb_reg[XB_W-1], s0_xb_reg};
        assign neg_next = d[XB_W];
        assign a        = neg_next ? (~d + 1'b1) : d;
        assign sat_next = |a[XB_W:FRAC_W];
        assign p        = P_W'(a[FRAC_W-1:0]) * P_W'(CDF_TABLE_ENTRIES);

        assign lo_next = PHI_ROM[s1_idx_reg];
        assign hi_next = PHI_ROM[IDX_W'(s1_idx_reg + 1'b1)];

        assign prod = MUL_W'(s2_diff_reg) * MUL_W'(s2_frac_reg);
        assign rnd  = {1'b0, prod} + (MUL_W + 1)'(1 << (FRAC_W - 1));
        assign sum  = {1'b0, s2_lo_reg} + rnd[MUL_W:FRAC_W];
        assign v    = (sum > {1'b0, PROB_ONE}) ? PROB_ONE : sum[PROB_W-1:0];

        always_comb
        begin
            if (s2_sat_reg)
            begin
                cum_next = s2_neg_reg ? '0 : PROB_ONE;
            end
            else if (s2_neg_reg)
            begin
                cum_next = PROB_ONE - v;
            end
            else
            begin
                cum_next = v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                s1_neg_reg    <= neg_next;
                s1_sat_reg    <= sat_next;
                s1_idx_reg    <= p[P_W-1:FRAC_W];
                s1_frac_reg   <= p[FRAC_W-1:0];
                s2_neg_reg    <= s1_neg_reg;
                s2_sat_reg    <= s1_sat_reg;
                s2_lo_reg     <= lo_next;
                s2_diff_reg   <= hi_next - lo_next;
                s2_frac_reg   <= s1_frac_reg;
                s3_cum_reg[g] <= cum_next;
            end
        end
    end

    // Drawn ordinal: one plus the cumulatives at or below the draw.
    logic [CAT_W-1:0] ordinal_next;

    always_comb
    begin
        ordinal_next = CAT_W'(1);
        for (int i = 0; i < MAX_CUTS; i++)
        begin
            if ((NCUT_W'(i) < n_eff) && (s3_cum_reg[i] <= {1'b0, s3_u_reg}))
            begin
                ordinal_next = ordinal_next + 1'b1;
            end
        end
    end

    // Result sequencer: emits one category per cycle, unless the output stalls, into the output register.
    logic              busy_reg;
    logic [NCUT_W-1:0] seq_idx_reg;
    logic [NCUT_W-1:0] seq_n_reg;
    logic [CAT_W-1:0]  seq_ord_reg;
    prob_t             seq_prev_reg;
    prob_t             seq_cum_reg [MAX_CUTS];
    logic              out_valid_reg;
    logic              out_free;
    logic              emit;
    logic              finish;
    prob_t             hi_sel;
    prob_t             prob_next;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = busy_reg && out_free;
    assign finish   = emit && (seq_idx_reg == seq_n_reg);
    assign load     = s3_valid_reg && (!busy_reg || finish);

    assign hi_sel    = (seq_idx_reg == seq_n_reg) ? PROB_ONE : seq_cum_reg[0];
    assign prob_next = (hi_sel > seq_prev_reg) ? (hi_sel - seq_prev_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [CAT_W-1:0]  category_reg;
    prob_t             category_prob_reg;
    logic              is_chosen_reg;
    logic [CAT_W-1:0]  ordinal_reg;
    logic              last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seq_idx_reg  <= '0;
            seq_n_reg    <= n_eff;
            seq_ord_reg  <= ordinal_next;
            seq_prev_reg <= '0;
            for (int i = 0; i < MAX_CUTS; i++)
            begin
                seq_cum_reg[i] <= s3_cum_reg[i];
            end
        end
        else if (emit)
        begin
            seq_idx_reg  <= seq_idx_reg + 1'b1;
            seq_prev_reg <= seq_cum_reg[0];
            for (int i = 0; i < MAX_CUTS - 1; i++)
            begin
                seq_cum_reg[i] <= seq_cum_reg[i + 1];
            end
        end
        if (emit)
        begin
            category_reg      <= CAT_W'(seq_idx_reg) + 1'b1;
            category_prob_reg <= prob_next;
            is_chosen_reg     <= (CAT_W'(seq_idx_reg) + 1'b1) == seq_ord_reg;
            ordinal_reg       <= seq_ord_reg;
            last_reg          <= seq_idx_reg == seq_n_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign category      = category_reg;
    assign category_prob = category_prob_reg;
    assign is_chosen     = is_chosen_reg;
    assign ordinal       = ordinal_reg;
    assign last          = last_reg;

endmodule

>>> tb/ordered_probit_category_draw_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ordered probit category draw, with its own category predictor.
module ordered_probit_category_draw_top_tb;

    import opcd_pkg::*;

    localparam int MAX_CUTS          = 6;
    localparam int CDF_TABLE_ENTRIES = 256;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;
    localparam int Q16_ONE           = 65536;

    typedef struct packed {
        logic [CAT_W-1:0]  cat;
        logic [PROB_W-1:0] prob;
        logic              chosen;
        logic [CAT_W-1:0]  ord;
        logic              last_f;
    } draw_result_t;

    class category_checker;
        localparam int ENTRIES = CDF_TABLE_ENTRIES;
        localparam logic [63:0] ONE_Q32_C = 64'h0000_0001_0000_0000;
        localparam logic [63:0] LN2_Q32_C = 64'd2977044472;
        localparam logic [63:0] INV_SQRT_2PI_C = 64'd1713444002;

        bit [31:0]    phi_tbl[ENTRIES+1];
        bit [2:0]     num_cuts;
        longint       cut_q[MAX_CUTS];
        draw_result_t pending_q[$];
        int           errors;

        function new();
            num_cuts = 1;
            foreach (cut_q[i]) cut_q[i] = 0;
            errors = 0;
            build_phi();
        endfunction

        function bit [63:0] exp_neg(bit [63:0] y);
            bit [63:0] q, r, term, sum;
            q = y / LN2_Q32_C;
            r = y - q * LN2_Q32_C;
            term = ONE_Q32_C;
            sum = ONE_Q32_C;
            for (bit [63:0] n = 1; n <= 14; n++)
            begin
                term = (term * r) >> 32;
                term = term / n;
                if (n[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (q >= 64)
                return 64'd0;
            return sum >> q;
        endfunction

        function bit [63:0] density(bit [63:0] j);
            bit [63:0] e, y;
            e = ENTRIES;
            y = ((j * j) << 35) / (e * e);
            return (exp_neg(y) * INV_SQRT_2PI_C) >> 32;
        endfunction

        function void build_phi();
            bit [63:0] e, acc, f0, fm, f1, s, v;
            e = ENTRIES;
            acc = 0;
            f0 = density(0);
            phi_tbl[0] = 32768;
            for (int k = 0; k < ENTRIES; k++)
            begin
                fm = density(2 * k + 1);
                f1 = density(2 * k + 2);
                s = f0 + 4 * fm + f1;
                acc = acc + (s * 4 + (3 * e) / 2) / (3 * e);
                v = ((64'd1 << 31) + acc + (64'd1 << 15)) >> 16;
                if (v > Q16_ONE)
                    v = Q16_ONE;
                phi_tbl[k+1] = v[31:0];
                f0 = f1;
            end
        endfunction

        function bit [16:0] normal_cdf(longint d);
            bit [63:0] a, p, idx, f, lo, hi, v;
            a = (d < 0) ? -d : d;
            if (a >= (64'd8 << 16))
                return (d >= 0) ? 17'd65536 : 17'd0;
            p = a * ENTRIES;
            idx = p >> 19;
            f = p & ((64'd1 << 19) - 1);
            lo = phi_tbl[idx];
            hi = phi_tbl[idx+1];
            v = lo + (((hi - lo) * f + (64'd1 << 18)) >> 19);
            if (v > Q16_ONE)
                v = Q16_ONE;
            return (d >= 0) ? v[16:0] : 17'(Q16_ONE - v);
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NUM_CUTS)
                num_cuts = data[2:0];
            else if (idx < CFG_CUT_POINT_0 + MAX_CUTS)
                cut_q[idx - CFG_CUT_POINT_0] = longint'($signed(data));
        endfunction

        function void note_draw(logic [XB_W-1:0] xb, logic [U_W-1:0] u);
            longint       sxb;
            bit [16:0]    cum[MAX_CUTS];
            bit [16:0]    hi, lo;
            int           n, ord;
            draw_result_t r;
            sxb = longint'($signed(xb));
            n = num_cuts;
            if (n < 1)
                n = 1;
            if (n > MAX_CUTS)
                n = MAX_CUTS;
            ord = 1;
            for (int i = 0; i < n; i++)
            begin
                cum[i] = normal_cdf(cut_q[i] - sxb);
                if (cum[i] <= {1'b0, u})
                    ord++;
            end
            for (int i = 0; i <= n; i++)
            begin
                hi = (i < n) ? cum[i] : 17'd65536;
                lo = (i > 0) ? cum[i-1] : 17'd0;
                r.cat = 3'(i + 1);
                r.prob = (hi > lo) ? hi - lo : 17'd0;
                r.chosen = (i + 1 == ord);
                r.ord = 3'(ord);
                r.last_f = (i == n);
                pending_q.push_back(r);
            end
        endfunction

        function void check_category(draw_result_t got);
            draw_result_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item cat=%0d prob=%0d chosen=%0d ord=%0d last=%0d",
                         $time, got.cat, got.prob, got.chosen, got.ord, got.last_f);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want)
            begin
                errors++;
                $display({"%0t: mismatch expected cat=%0d prob=%0d chosen=%0d ord=%0d ",
                          "last=%0d, actual cat=%0d prob=%0d chosen=%0d ord=%0d last=%0d"},
                         $time, want.cat, want.prob, want.chosen, want.ord, want.last_f,
                         got.cat, got.prob, got.chosen, got.ord, got.last_f);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [XB_W-1:0]        linear_predictor;
    logic [U_W-1:0]         uniform_draw;
    logic                   out_valid;
    logic                   out_ready;
    logic [CAT_W-1:0]       category;
    logic [PROB_W-1:0]      category_prob;
    logic                   is_chosen;
    logic [CAT_W-1:0]       ordinal;
    logic                   last;

    category_checker chk;
    int  snd_idle;
    int  rcv_stall;
    bit  hold_req;
    int  hold_left;
    int  cut_val[MAX_CUTS];
    int  mid_cut;

    ordered_probit_category_draw_top #(
        .MAX_CUTS          (MAX_CUTS),
        .CDF_TABLE_ENTRIES (CDF_TABLE_ENTRIES)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .linear_predictor (linear_predictor),
        .uniform_draw     (uniform_draw),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .category         (category),
        .category_prob    (category_prob),
        .is_chosen        (is_chosen),
        .ordinal          (ordinal),
        .last             (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("ordered_probit_category_draw_top test failed");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 90;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rcv_stall);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                chk.check_category('{category, category_prob, is_chosen, ordinal, last});
        end
    end

    task automatic push_item(logic [XB_W-1:0] xb, logic [U_W-1:0] u);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        linear_predictor <= xb;
        uniform_draw <= u;
        do
            @(posedge clk);
        while (!in_ready);
        chk.note_draw(xb, u);
    endtask

    task automatic wait_drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (chk.pending_q.size() > 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (chk.pending_q.size() > 0)
        begin
            chk.errors++;
            $display("%0t: %0d expected items never arrived", $time, chk.pending_q.size());
            chk.pending_q.delete();
        end
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        chk.set_reg(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(int n);
        cfg_write(CFG_NUM_CUTS, CFG_DATA_W'(n));
        for (int i = 0; i < MAX_CUTS; i++)
            cfg_write(CFG_INDEX_W'(CFG_CUT_POINT_0 + i), CFG_DATA_W'(cut_val[i]));
    endtask

    task automatic random_cuts();
        int c;
        if ($urandom_range(0, 3) == 0)
        begin
            foreach (cut_val[i]) cut_val[i] = int'($signed(24'($urandom)));
            mid_cut = 0;
        end
        else
        begin
            c = $urandom_range(0, 4 * Q16_ONE) - 4 * Q16_ONE;
            foreach (cut_val[i])
            begin
                cut_val[i] = c;
                c += $urandom_range(0, 2 * Q16_ONE);
            end
            mid_cut = cut_val[2];
        end
    endtask

    task automatic random_item();
        logic [XB_W-1:0] xb;
        logic [U_W-1:0]  u;
        if ($urandom_range(0, 3) == 0)
            xb = 24'($urandom);
        else
            xb = 24'(mid_cut + $urandom_range(0, 10 * Q16_ONE) - 5 * Q16_ONE);
        case ($urandom_range(0, 9))
            0:       u = 16'd0;
            1:       u = 16'hFFFF;
            default: u = 16'($urandom_range(0, 65535));
        endcase
        push_item(xb, u);
    endtask

    initial
    begin
        chk = new();
        snd_idle = 0;
        rcv_stall = 0;
        hold_req = 1'b0;
        mid_cut = 0;
        rst_n = 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        linear_predictor <= '0;
        uniform_draw <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a single cut at zero, including the table edge at eight.
        push_item(24'd0, 16'd0);
        push_item(24'd0, 16'hFFFF);
        push_item(24'd0, 16'd32768);
        push_item(24'h7FFFFF, 16'd0);
        push_item(24'h800000, 16'hFFFF);
        push_item(24'(-524287), 16'd100);
        push_item(24'd524288, 16'd100);
        push_item(24'(-524288), 16'd5);
        wait_drain();

        // Writes beyond the register list must be ignored.
        cfg_write(CFG_SPARE, 24'hA5A5A5);
        cut_val = '{-8388608, -65536, 0, 0, 196608, 8388607};
        load_config(MAX_CUTS);
        push_item(24'd0, 16'd0);
        push_item(24'd0, 16'hFFFF);
        push_item(24'd0, 16'd40000);
        push_item(24'd123456, 16'd30000);
        wait_drain();

        // Out-of-range cut counts saturate.
        cfg_write(CFG_NUM_CUTS, 24'd0);
        push_item(24'd65536, 16'd20000);
        push_item(24'h7FFFFF, 16'd1);
        wait_drain();
        cfg_write(CFG_NUM_CUTS, 24'd7);
        push_item(24'd0, 16'd50000);
        push_item(24'h800000, 16'd65534);
        wait_drain();

        // Descending cuts give zero-probability middle categories.
        cut_val = '{327680, 196608, 65536, -65536, -196608, -327680};
        load_config(MAX_CUTS);
        push_item(24'd0, 16'd10000);
        push_item(24'd0, 16'd60000);
        push_item(24'(-131072), 16'd32768);
        wait_drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 46; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 46; end
                default: begin snd_idle = 36; rcv_stall = 36; end
            endcase
            random_cuts();
            case (phase)
                0: load_config(MAX_CUTS);
                1: load_config(1);
                default: load_config($urandom_range(0, 7));
            endcase
            if (phase == 0)
                hold_req = 1'b1;
            repeat (50) random_item();
            wait_drain();
        end

        repeat (20) @(posedge clk);
        if (chk.errors == 0)
            $display("ordered_probit_category_draw_top test passed");
        else
            $display("ordered_probit_category_draw_top test failed");
        $finish;
    end

endmodule

>>> files.f
hdl/opcd_pkg.sv
hdl/ordered_probit_category_draw_top.sv
tb/ordered_probit_category_draw_top_tb.sv
